// File: rtl/sept_pkg.sv
// ============================================================================
// sept_pkg
// Shared types and constants for the snapshot epoch tracker: request codes,
// field widths, the scan word that travels along the cell chain and the
// controller states.
// ============================================================================
package sept_pkg;

   localparam int EPOCH_W     = 64;
   localparam int THREAD_ID_W = 4;
   localparam int ACTIVE_W    = 5;
   localparam int REQ_W       = 2;

   // active thread count after reset
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   // request codes, the fourth code only reports
   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 2'd0,
      REQ_REGIST = 2'd1,
      REQ_UPDATE = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   // scan word handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic [EPOCH_W-1:0] low;
      logic               reached;
      logic [EPOCH_W-1:0] pick;
   } link_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

endpackage

// File: rtl/sept_cell.sv
// ============================================================================
// sept_cell
// One worker entry: holds the thread epoch, takes writes and folds its entry
// into the scan word (running minimum, all-reached flag, picked entry) on its
// way to the next cell.
// ============================================================================
module sept_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [sept_pkg::EPOCH_W-1:0]    wr_data,
   input  logic                            act,
   input  logic                            pick_en,
   input  logic [sept_pkg::EPOCH_W-1:0]    threshold,
   input  sept_pkg::link_type              link_prev,
   output sept_pkg::link_type              link_next
);
   import sept_pkg::*;

   logic [EPOCH_W-1:0] epoch_ff;
   link_type           link_ff;
   link_type           link_in;

   // entry storage, every entry starts at one
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= EPOCH_W'(1);
      end else if (wr_en) begin
         epoch_ff <= wr_data;
      end
   end

   // fold this entry into the passing word
   always_comb begin
      link_in = link_prev;
      if (act) begin
         if (epoch_ff < link_prev.low) begin
            link_in.low = epoch_ff;
         end
         if (epoch_ff < threshold) begin
            link_in.reached = 1'b0;
         end
      end
      if (pick_en) begin
         link_in.pick = epoch_ff;
      end
   end

   // hand-off register to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff <= link_in;
      end
   end

   assign link_next = link_ff;

endmodule

// File: rtl/sept_chain.sv
// ============================================================================
// sept_chain
// Row of worker cells. Decodes the write target, the picked entry and the
// active mask, and moves the scan word one cell per cycle.
// ============================================================================
module sept_chain #(
   parameter int MAX_THREADS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [sept_pkg::THREAD_ID_W-1:0]    wr_id,
   input  logic [sept_pkg::EPOCH_W-1:0]        wr_data,
   input  logic [sept_pkg::THREAD_ID_W-1:0]    pick_id,
   input  logic [sept_pkg::ACTIVE_W-1:0]       active_cnt,
   input  logic [sept_pkg::EPOCH_W-1:0]        threshold,
   input  logic                                start,
   output sept_pkg::link_type                  tail
);
   import sept_pkg::*;

   link_type links [0:MAX_THREADS];

   // fresh scan word: neutral minimum, flag set
   always_comb begin
      links[0].valid   = start;
      links[0].low     = '1;
      links[0].reached = 1'b1;
      links[0].pick    = '0;
   end

   for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
      logic act;
      logic sel_wr;
      logic sel_pick;

      // entry zero always counts, the count is clamped to at least one
      assign act      = (i == 0) || (int'(active_cnt) > i);
      assign sel_wr   = wr_en && (int'(wr_id) == i);
      assign sel_pick = (int'(pick_id) == i);

      sept_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (sel_wr),
         .wr_data   (wr_data),
         .act       (act),
         .pick_en   (sel_pick),
         .threshold (threshold),
         .link_prev (links[i]),
         .link_next (links[i+1])
      );
   end

   assign tail = links[MAX_THREADS];

endmodule

// File: rtl/snapshot_epoch_tracker_top.sv
// ============================================================================
// snapshot_epoch_tracker_top
// Global snapshot epoch plus one epoch per worker, reporting the read
// snapshot (low watermark minus one) and an all-reached flag per request.
// ============================================================================
// The request is applied at its accept edge. A scan word then walks the
// cell row one worker per cycle, collecting the minimum, the all-reached
// flag and the named entry. The result is parked and then moved into the
// response register. One request is in flight at a time: req_ready rises
// again at the edge that loads the response, and no new request is taken
// before that load. A new request is taken while the previous response
// still waits on rsp_ready; its result then waits in the hold state until
// that response is taken. csr_wr_data sets the active thread count (0 acts
// as 1, values above MAX_THREADS as MAX_THREADS). A thread id outside the
// active count sets rsp_thread_error and reports an entry of 0, and a
// register or update request with it changes nothing.
module snapshot_epoch_tracker_top #(
   parameter int MAX_THREADS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sept_pkg::REQ_W-1:0]          req_type,
   input  logic [sept_pkg::THREAD_ID_W-1:0]    req_thread_id,
   input  logic [sept_pkg::EPOCH_W-1:0]        req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sept_pkg::EPOCH_W-1:0]        rsp_current_epoch,
   output logic [sept_pkg::EPOCH_W-1:0]        rsp_thread_epoch,
   output logic [sept_pkg::EPOCH_W-1:0]        rsp_read_snapshot,
   output logic                                rsp_all_reached,
   output logic                                rsp_thread_error,
   input  logic                                csr_wr_en,
   input  logic [sept_pkg::ACTIVE_W-1:0]       csr_wr_data
);
   import sept_pkg::*;

   state_type                state_ff, state_in;
   logic [ACTIVE_W-1:0]      active_ff;
   logic [EPOCH_W-1:0]       global_ff;
   logic [EPOCH_W-1:0]       value_ff;
   logic [THREAD_ID_W-1:0]   tid_ff;
   logic                     bad_ff;
   logic                     start_ff;
   link_type                 res_ff;
   link_type                 tail;
   logic                     accept;
   logic                     id_ok;
   logic                     wr_en;
   logic [EPOCH_W-1:0]       wr_data;
   logic                     load_rsp;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [EPOCH_W-1:0]       cur_ep_ff;
   logic [EPOCH_W-1:0]       thr_ep_ff;
   logic [EPOCH_W-1:0]       snap_ff;
   logic                     reached_ff;
   logic                     err_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // id is live when below the clamped active count
   assign id_ok = (int'(req_thread_id) < MAX_THREADS) &&
                  ((req_thread_id == '0) || (int'(req_thread_id) < int'(active_ff)));

   // entry write decode
   always_comb begin
      wr_en   = 1'b0;
      wr_data = req_value;
      case (req_type)
         REQ_REGIST: begin
            wr_en   = accept && id_ok;
            wr_data = EPOCH_W'(1);
         end
         REQ_UPDATE: begin
            wr_en   = accept && id_ok;
         end
         default: begin
            wr_en   = 1'b0;
         end
      endcase
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   // global epoch, wraps on overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         global_ff <= EPOCH_W'(1);
      end else if (accept && req_type == REQ_TICK) begin
         global_ff <= global_ff + EPOCH_W'(1);
      end
   end

   // per-request context held through the scan
   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff <= req_value;
         tid_ff   <= req_thread_id;
         bad_ff   <= !id_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
      end else begin
         start_ff <= accept;
      end
   end

   sept_chain #(
      .MAX_THREADS (MAX_THREADS)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_id      (req_thread_id),
      .wr_data    (wr_data),
      .pick_id    (tid_ff),
      .active_cnt (active_ff),
      .threshold  (value_ff),
      .start      (start_ff),
      .tail       (tail)
   );

   // park the finished scan word
   always_ff @(posedge clock) begin
      if (tail.valid) begin
         res_ff <= tail;
      end
   end

   // controller state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and response load
   always_comb begin
      state_in = state_ff;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail.valid) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         cur_ep_ff  <= global_ff;
         thr_ep_ff  <= bad_ff ? '0 : res_ff.pick;
         snap_ff    <= (res_ff.low == '0) ? '0 : res_ff.low - EPOCH_W'(1);
         reached_ff <= res_ff.reached;
         err_ff     <= bad_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_epoch = cur_ep_ff;
   assign rsp_thread_epoch  = thr_ep_ff;
   assign rsp_read_snapshot = snap_ff;
   assign rsp_all_reached   = reached_ff;
   assign rsp_thread_error  = err_ff;

endmodule

// File: sim/snapshot_epoch_tracker_top_tb.sv
// ============================================================================
// snapshot_epoch_tracker_top_tb
// Self-checking bench for the snapshot epoch tracker. A short table of
// directed requests and active-count writes runs first, then 1830
// random requests in phases with different active counts. Each accepted
// request word goes through a behavioral tracker model in the bench; every
// response word is compared field by field with the oldest prediction.
// Both handshake sides idle at random, with one long response stall that
// backs the block up into its request port.
// ============================================================================
module snapshot_epoch_tracker_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sept_pkg::*;

   localparam int          NUM_WORKERS  = 16;
   localparam int          HALF_PERIOD  = 6;
   localparam int          SETTLE       = 2 * (NUM_WORKERS + 3);
   localparam int          RAND_PHASES  = 10;
   localparam int          PHASE_ITEMS  = 183;
   localparam int          LONG_HOLD    = 250;
   localparam int          HOLD_AT      = 600;
   localparam int          MAX_REPORTS  = 10;
   localparam longint      TIMEOUT_NS   = 64'd5_000_000;
   localparam logic [EPOCH_W-1:0] ALL_ONES = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] TOP_BIT  = {1'b1, {(EPOCH_W-1){1'b0}}};

   // one response word
   typedef struct packed {
      logic [EPOCH_W-1:0] cur;
      logic [EPOCH_W-1:0] thr;
      logic [EPOCH_W-1:0] snap;
      logic               reached;
      logic               err;
   } epoch_rsp_type;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_TYPED,
      ROW_CSR
   } row_kind_type;

   // one line of the directed table
   typedef struct packed {
      row_kind_type             kind;
      req_code_type             code;
      logic [THREAD_ID_W-1:0]   tid;
      logic [EPOCH_W-1:0]       val;
      epoch_rsp_type            want;
   } dir_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [REQ_W-1:0]         req_type;
   logic [THREAD_ID_W-1:0]   req_thread_id;
   logic [EPOCH_W-1:0]       req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [EPOCH_W-1:0]       rsp_current_epoch;
   logic [EPOCH_W-1:0]       rsp_thread_epoch;
   logic [EPOCH_W-1:0]       rsp_read_snapshot;
   logic                     rsp_all_reached;
   logic                     rsp_thread_error;
   logic                     csr_wr_en;
   logic [ACTIVE_W-1:0]      csr_wr_data;

   // tracker model state
   logic [EPOCH_W-1:0]       snap_epoch;
   logic [EPOCH_W-1:0]       worker_epoch [NUM_WORKERS];
   logic [ACTIVE_W-1:0]      worker_limit;

   epoch_rsp_type            pending_rsp [$];
   dir_row_type              dir_table [$];

   int                       error_count;
   int                       mismatch_count;
   int                       checked_count;
   int                       sent_count;
   int                       csr_count;
   int                       error_rsp_count;
   int                       reached_count;
   bit                       send_calm;
   bit                       recv_calm;
   bit                       hold_done;

   snapshot_epoch_tracker_top #(
      .MAX_THREADS (NUM_WORKERS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_thread_id     (req_thread_id),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_epoch (rsp_current_epoch),
      .rsp_thread_epoch  (rsp_thread_epoch),
      .rsp_read_snapshot (rsp_read_snapshot),
      .rsp_all_reached   (rsp_all_reached),
      .rsp_thread_error  (rsp_thread_error),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // clock
   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // active count after clamping to 1..NUM_WORKERS
   function automatic int worker_count();
      if (worker_limit == 0)
         return 1;
      if (int'(worker_limit) > NUM_WORKERS)
         return NUM_WORKERS;
      return int'(worker_limit);
   endfunction

   // low watermark over the active entries
   function automatic logic [EPOCH_W-1:0] lowest_epoch();
      logic [EPOCH_W-1:0] lo;
      lo = worker_epoch[0];
      for (int i = 1; i < worker_count(); i++)
         if (worker_epoch[i] < lo)
            lo = worker_epoch[i];
      return lo;
   endfunction

   // apply one request to the tracker model and return its response word
   function automatic epoch_rsp_type track_request(req_code_type code,
                                                   logic [THREAD_ID_W-1:0] tid,
                                                   logic [EPOCH_W-1:0] val);
      epoch_rsp_type      r;
      logic               bad;
      logic [EPOCH_W-1:0] lo;
      bad = int'(tid) >= worker_count();
      case (code)
         REQ_TICK: begin
            snap_epoch = snap_epoch + 64'd1;
         end
         REQ_REGIST: begin
            if (!bad)
               worker_epoch[tid] = 64'd1;
         end
         REQ_UPDATE: begin
            if (!bad)
               worker_epoch[tid] = val;
         end
         default: ;
      endcase
      lo        = lowest_epoch();
      r.cur     = snap_epoch;
      r.thr     = bad ? '0 : worker_epoch[tid];
      r.snap    = (lo == 0) ? '0 : lo - 64'd1;
      // every active entry reaches val exactly when the lowest one does
      r.reached = (lo >= val);
      r.err     = bad;
      return r;
   endfunction

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic void add_row(row_kind_type kind, req_code_type code, int tid,
                                   logic [EPOCH_W-1:0] val, logic [EPOCH_W-1:0] cur,
                                   logic [EPOCH_W-1:0] thr, logic [EPOCH_W-1:0] snap,
                                   bit reached, bit err);
      dir_row_type row;
      row.kind         = kind;
      row.code         = code;
      row.tid          = tid[THREAD_ID_W-1:0];
      row.val          = val;
      row.want.cur     = cur;
      row.want.thr     = thr;
      row.want.snap    = snap;
      row.want.reached = reached;
      row.want.err     = err;
      dir_table.push_back(row);
   endfunction

   // offer one request word, record its prediction once accepted
   task automatic send_request(req_code_type code, logic [THREAD_ID_W-1:0] tid,
                               logic [EPOCH_W-1:0] val, bit typed, epoch_rsp_type want);
      int            gap;
      epoch_rsp_type pred;
      if ($urandom_range(0, 63) == 0)
         send_calm = ~send_calm;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= code;
      req_thread_id <= tid;
      req_value     <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = track_request(code, tid, val);
      pending_rsp.push_back(typed ? want : pred);
      sent_count++;
   endtask

   // wait until every response is back and the block has gone quiet
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_active(logic [ACTIVE_W-1:0] count);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      worker_limit  = count;
      csr_count++;
   endtask

   // request value: extremes, full random, or near the epochs in play
   function automatic logic [EPOCH_W-1:0] pick_value(req_code_type code);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ALL_ONES;
         2, 3:    return {$urandom, $urandom};
         4, 5:    return lowest_epoch() + 64'($urandom_range(0, 2));
         default: begin
            if (code == REQ_UPDATE)
               return snap_epoch + 64'($urandom_range(0, 6));
            return lowest_epoch() - 64'($urandom_range(0, 2));
         end
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin : rsp_check
      epoch_rsp_type want;
      bit            bad_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (mismatch_count < MAX_REPORTS)
               $display("%0t: response word with nothing pending", $realtime);
            mismatch_count++;
         end else begin
            want     = pending_rsp.pop_front();
            bad_word = (rsp_current_epoch !== want.cur) ||
                       (rsp_thread_epoch  !== want.thr) ||
                       (rsp_read_snapshot !== want.snap) ||
                       (rsp_all_reached   !== want.reached) ||
                       (rsp_thread_error  !== want.err);
            if (bad_word) begin
               error_count++;
               if (mismatch_count < MAX_REPORTS) begin
                  $display("%0t: mismatch on response %0d", $realtime, checked_count);
                  $display("   epoch    exp %h got %h", want.cur, rsp_current_epoch);
                  $display("   thread   exp %h got %h", want.thr, rsp_thread_epoch);
                  $display("   snapshot exp %h got %h", want.snap, rsp_read_snapshot);
                  $display("   reached  exp %b got %b  error exp %b got %b",
                           want.reached, rsp_all_reached, want.err, rsp_thread_error);
               end
               mismatch_count++;
            end
            if (want.err)
               error_rsp_count++;
            if (want.reached)
               reached_count++;
            checked_count++;
         end
      end
   end

   // response side: random stalls, one long hold to back the block up
   initial begin : rsp_drive
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0)
            recv_calm = ~recv_calm;
         stall = draw_wait(recv_calm);
         if (!hold_done && checked_count >= HOLD_AT) begin
            stall     = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // stimulus
   initial begin : stim
      int                     cfg_plan [RAND_PHASES];
      epoch_rsp_type          blank;
      req_code_type           code;
      logic [THREAD_ID_W-1:0] tid;
      int                     pick;

      req_valid     = 1'b0;
      req_type      = REQ_TICK;
      req_thread_id = '0;
      req_value     = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      reset         = 1'b1;
      error_count   = 0;
      mismatch_count = 0;
      checked_count = 0;
      sent_count    = 0;
      csr_count     = 0;
      error_rsp_count = 0;
      reached_count = 0;
      send_calm     = 1'b0;
      recv_calm     = 1'b0;
      hold_done     = 1'b0;
      blank         = '0;

      // model state after reset
      snap_epoch   = 64'd1;
      worker_limit = ACTIVE_RESET;
      for (int i = 0; i < NUM_WORKERS; i++)
         worker_epoch[i] = 64'd1;

      // directed table: kind, code, thread, value | epoch, entry, snapshot, reached, error
      add_row(ROW_TYPED,   REQ_TICK,   0,  0,        2, 1,        0,  1, 0);
      add_row(ROW_TYPED,   REQ_NONE,   15, 1,        2, 1,        0,  1, 0);
      add_row(ROW_TYPED,   REQ_NONE,   15, 2,        2, 1,        0,  0, 0);
      // an entry of zero pins the snapshot at zero
      add_row(ROW_TYPED,   REQ_UPDATE, 3,  0,        2, 0,        0,  1, 0);
      add_row(ROW_TYPED,   REQ_UPDATE, 15, ALL_ONES, 2, ALL_ONES, 0,  0, 0);
      add_row(ROW_TYPED,   REQ_REGIST, 3,  0,        2, 1,        0,  1, 0);
      add_row(ROW_TYPED,   REQ_REGIST, 15, 1,        2, 1,        0,  1, 0);
      // single worker, ids above it are rejected
      add_row(ROW_CSR,     REQ_NONE,   0,  1,        0, 0,        0,  0, 0);
      add_row(ROW_TYPED,   REQ_UPDATE, 0,  100,      2, 100,      99, 1, 0);
      add_row(ROW_TYPED,   REQ_UPDATE, 1,  5,        2, 0,        99, 1, 1);
      add_row(ROW_TYPED,   REQ_REGIST, 15, 101,      2, 0,        99, 0, 1);
      add_row(ROW_TYPED,   REQ_TICK,   1,  0,        3, 0,        99, 1, 1);
      // a count of zero behaves as one
      add_row(ROW_CSR,     REQ_NONE,   0,  0,        0, 0,        0,  0, 0);
      add_row(ROW_TYPED,   REQ_UPDATE, 1,  7,        3, 0,        99, 1, 1);
      add_row(ROW_TYPED,   REQ_NONE,   0,  100,      3, 100,      99, 1, 0);
      // counts above the worker total clamp to all workers
      add_row(ROW_CSR,     REQ_NONE,   0,  31,       0, 0,        0,  0, 0);
      add_row(ROW_TYPED,   REQ_NONE,   15, 0,        3, 1,        0,  1, 0);
      add_row(ROW_PREDICT, REQ_UPDATE, 8,  ALL_ONES, 0, 0,        0,  0, 0);
      add_row(ROW_PREDICT, REQ_REGIST, 8,  3,        0, 0,        0,  0, 0);
      add_row(ROW_CSR,     REQ_NONE,   0,  17,       0, 0,        0,  0, 0);
      add_row(ROW_PREDICT, REQ_NONE,   15, ALL_ONES, 0, 0,        0,  0, 0);
      add_row(ROW_PREDICT, REQ_UPDATE, 15, TOP_BIT,  0, 0,        0,  0, 0);
      add_row(ROW_CSR,     REQ_NONE,   0,  16,       0, 0,        0,  0, 0);
      add_row(ROW_PREDICT, REQ_TICK,   5,  2,        0, 0,        0,  0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CSR) begin
            drain_block();
            write_active(dir_table[i].val[ACTIVE_W-1:0]);
         end else begin
            send_request(dir_table[i].code, dir_table[i].tid, dir_table[i].val,
                         dir_table[i].kind == ROW_TYPED, dir_table[i].want);
         end
      end

      // random part, one active count per phase
      cfg_plan = '{16, 1, 0, 31, 8, 17, 2, 15, 0, 0};
      cfg_plan[8] = $urandom_range(1, 16);
      cfg_plan[9] = $urandom_range(0, 31);
      for (int p = 0; p < RAND_PHASES; p++) begin
         drain_block();
         write_active(cfg_plan[p][ACTIVE_W-1:0]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 5)
               code = REQ_TICK;
            else if (pick < 7)
               code = REQ_REGIST;
            else if (pick < 18)
               code = REQ_UPDATE;
            else
               code = REQ_NONE;
            if ($urandom_range(0, 3) != 0)
               tid = THREAD_ID_W'($urandom_range(0, worker_count() - 1));
            else
               tid = THREAD_ID_W'($urandom_range(0, NUM_WORKERS - 1));
            send_request(code, tid, pick_value(code), 1'b0, blank);
         end
      end

      // wind down
      drain_block();
      if (pending_rsp.size() != 0)
         error_count += pending_rsp.size();

      $display("covered %0d request words over %0d active-count writes, %0d responses checked",
               sent_count, csr_count, checked_count);
      $display("responses with thread error %0d, with all reached %0d, mismatches %0d",
               error_rsp_count, reached_count, mismatch_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: snapshot_epoch_tracker_top.f
rtl/sept_pkg.sv
rtl/sept_cell.sv
rtl/sept_chain.sv
rtl/snapshot_epoch_tracker_top.sv
sim/snapshot_epoch_tracker_top_tb.sv
